// ===== hw/rtl/hee_pkg.sv =====
// shared types, constants and entity lookup for the html entity escaper
// no dependencies
package hee_pkg;

    localparam int CNT_W = 17;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CHR_AMP = 8'h26;
    localparam logic [7:0] CHR_LT = 8'h3c;
    localparam logic [7:0] CHR_GT = 8'h3e;
    localparam logic [7:0] CHR_QUOT = 8'h22;
    localparam logic [7:0] CHR_APOS = 8'h27;

    localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;
    localparam logic [CNT_W-1:0] BUFFER_SIZE_RESET = 17'd256;

    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_ENT = 2'd1,
        CMD_TERM = 2'd2
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ENT_AMP = 3'd0,
        ENT_LT = 3'd1,
        ENT_GT = 3'd2,
        ENT_QUOT = 3'd3,
        ENT_APOS = 3'd4
    } ent_sel_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic [7:0] ch;
        ent_sel_t ent;
    } cmd_t;

    localparam logic [47:0] STR_AMP = {"&amp;", 8'h00};
    localparam logic [47:0] STR_LT = {"&lt;", 16'h0000};
    localparam logic [47:0] STR_GT = {"&gt;", 16'h0000};
    localparam logic [47:0] STR_QUOT = "&quot;";
    localparam logic [47:0] STR_APOS = {"&#39;", 8'h00};

    function automatic logic [2:0] ent_len(input ent_sel_t sel);
        logic [2:0] len;
        unique case (sel)
            ENT_AMP: len = 3'd5;
            ENT_LT: len = 3'd4;
            ENT_GT: len = 3'd4;
            ENT_QUOT: len = 3'd6;
            ENT_APOS: len = 3'd5;
            default: len = 3'd5;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] ent_char(input ent_sel_t sel, input logic [2:0] idx);
        logic [47:0] s;
        logic [47:0] sh;
        unique case (sel)
            ENT_AMP: s = STR_AMP;
            ENT_LT: s = STR_LT;
            ENT_GT: s = STR_GT;
            ENT_QUOT: s = STR_QUOT;
            ENT_APOS: s = STR_APOS;
            default: s = STR_AMP;
        endcase
        sh = s << {idx, 3'b000};
        return sh[47:40];
    endfunction

endpackage

// ===== hw/rtl/html_entity_escaper.sv =====
// top level of the html entity escaper: apb register, front end, queue, back end
// depends on hee_pkg, hee_front, hee_cmd_fifo, hee_back
//
// Streams a zero-terminated string in one byte per transfer and streams the
// escaped string out, replacing & < > " ' with their entities. Ordinary bytes
// pass at one per cycle unless the output stalls, through the queue and the
// back end's output register; an escaped character becomes four to six entity
// bytes, also one per cycle, while the four-entry queue lets input continue.
// buffer_size (byte address 0) bounds the string including its terminator;
// entities that do not fit are dropped, and bytes past the limit are ignored.
// A zero byte gives a zero output byte with tlast set and starts a new string.
module html_entity_escaper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);
    import hee_pkg::*;

    logic [CNT_W-1:0] buffer_size_reg;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    cmd_t             push_cmd;
    cmd_t             head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? {15'd0, buffer_size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= BUFFER_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_BUFFER_SIZE)
        begin
            buffer_size_reg <= pwdata[CNT_W-1:0];
        end
    end

    hee_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .buffer_size (buffer_size_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    hee_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    hee_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/hee_front.sv =====
// front end: accepts input bytes, tracks the output count, classifies each byte
// depends on hee_pkg
module hee_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [hee_pkg::CNT_W-1:0] buffer_size,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    input  logic                      q_full,
    output logic                      q_push,
    output hee_pkg::cmd_t             q_cmd
);
    import hee_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] limit;
    logic             accept;
    logic             special;
    ent_sel_t         sel;
    logic [CNT_W:0]   sum;

    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;
    assign limit = (buffer_size == '0) ? '0 : buffer_size - 1'b1;

    always_comb
    begin
        special = 1'b1;
        sel = ENT_AMP;
        unique case (in_byte)
            CHR_AMP: sel = ENT_AMP;
            CHR_LT: sel = ENT_LT;
            CHR_GT: sel = ENT_GT;
            CHR_QUOT: sel = ENT_QUOT;
            CHR_APOS: sel = ENT_APOS;
            default: special = 1'b0;
        endcase
    end

    assign sum = {1'b0, count_reg} + (CNT_W + 1)'(ent_len(sel));

    always_comb
    begin
        count_next = count_reg;
        q_push = 1'b0;
        q_cmd.kind = CMD_CHAR;
        q_cmd.ch = in_byte;
        q_cmd.ent = sel;
        if (accept)
        begin
            priority if (in_byte == 8'h00)
            begin
                q_push = 1'b1;
                q_cmd.kind = CMD_TERM;
                count_next = '0;
            end
            else if (count_reg >= limit)
            begin
                q_push = 1'b0;
            end
            else if (!special)
            begin
                q_push = 1'b1;
                count_next = count_reg + 1'b1;
            end
            else if (sum <= {1'b0, limit})
            begin
                q_push = 1'b1;
                q_cmd.kind = CMD_ENT;
                count_next = sum[CNT_W-1:0];
            end
            else
            begin
                // entity does not fit, dropped
                q_push = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/hee_cmd_fifo.sv =====
// short command queue between front and back end
// depends on hee_pkg
module hee_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hee_pkg::cmd_t push_cmd,
    input  logic          pop,
    output hee_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import hee_pkg::*;

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign empty = (count_reg == '0);
    assign full = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/hee_back.sv =====
// back end: expands queued commands into output bytes, one per cycle unless the output stalls
// depends on hee_pkg
module hee_back (
    input  logic          clk,
    input  logic          rst_n,
    input  hee_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last
);
    import hee_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       load;
    logic [7:0] byte_next;
    logic       last_next;

    assign load = (!valid_reg || out_ready) && !q_empty;

    always_comb
    begin
        byte_next = head.ch;
        last_next = 1'b0;
        q_pop = 1'b0;
        pos_next = pos_reg;
        if (load)
        begin
            unique case (head.kind)
                CMD_ENT:
                begin
                    byte_next = ent_char(head.ent, pos_reg);
                    if (pos_reg == ent_len(head.ent) - 3'd1)
                    begin
                        q_pop = 1'b1;
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
                CMD_TERM:
                begin
                    byte_next = 8'h00;
                    last_next = 1'b1;
                    q_pop = 1'b1;
                end
                default:
                begin
                    q_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_byte = byte_reg;
    assign out_last = last_reg;

endmodule

// ===== tb/sv/html_entity_escaper_tb.sv =====
// self-checking testbench for html_entity_escaper: directed and random strings,
// escaped output predicted per transfer and compared beat by beat
// depends on hee_pkg and html_entity_escaper
`timescale 1ns / 100ps

module html_entity_escaper_tb;

    import hee_pkg::*;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 120;
    localparam int HOLD_SPACING = 40;
    localparam int PHASE_ITEMS = 18;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] out_byte
    logic        m_axis_tlast;

    logic [7:0]  text_q[$];
    out_beat_t   escaped_q[$];
    out_beat_t   beat;

    logic [16:0] size_model = BUFFER_SIZE_RESET;
    int unsigned count_model = 0;
    int          in_total = 0;
    int          errors = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          next_hold_at = HOLD_SPACING;

    logic [7:0]  specials[5];

    html_entity_escaper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void escape_char(input logic [7:0] ch);
        string       ent;
        int unsigned lim;
        ent = "";
        lim = (size_model == 17'd0) ? 0 : int'(size_model) - 1;
        if (ch == 8'h00)
        begin
            escaped_q.push_back(out_beat_t'{out_byte: 8'h00, out_last: 1'b1});
            count_model = 0;
            return;
        end
        if (count_model >= lim)
            return;
        case (ch)
            CHR_AMP: ent = "&amp;";
            CHR_LT: ent = "&lt;";
            CHR_GT: ent = "&gt;";
            CHR_QUOT: ent = "&quot;";
            CHR_APOS: ent = "&#39;";
            default: ent = "";
        endcase
        if (ent.len() == 0)
        begin
            escaped_q.push_back(out_beat_t'{out_byte: ch, out_last: 1'b0});
            count_model++;
        end
        else if (count_model + ent.len() <= lim)
        begin
            for (int i = 0; i < ent.len(); i++)
                escaped_q.push_back(out_beat_t'{out_byte: ent[i], out_last: 1'b0});
            count_model += ent.len();
        end
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                escape_char(s_axis_tdata);
                in_total++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (text_q.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= text_q.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: long hold-offs now and then, otherwise a rotating stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (hold_left == 0 && in_total >= next_hold_at)
            begin
                hold_left = HOLD_CYCLES;
                next_hold_at += HOLD_SPACING;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case ((cycle_count / 50) % 4)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= (cycle_count % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (escaped_q.size() == 0)
            begin
                $error("unexpected output transfer: out_byte %h out_last %b",
                       m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                beat = escaped_q.pop_front();
                if (m_axis_tdata !== beat.out_byte)
                begin
                    $error("out_byte mismatch: expected %h, actual %h",
                           beat.out_byte, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== beat.out_last)
                begin
                    $error("out_last mismatch: expected %b, actual %b",
                           beat.out_last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // checked between rising edges so the sender state has settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (text_q.size() != 0 || s_axis_tvalid || escaped_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write buffer_size, then read it back
    task automatic set_buffer_size(input logic [16:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_BUFFER_SIZE, 2'b00};
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        size_model = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(value))
        begin
            $error("buffer_size readback mismatch: expected %h, actual %h",
                   32'(value), prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // random text with a fair share of escaped characters; some strings left open
    task automatic push_string(input int max_len);
        int len;
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) < 3)
                text_q.push_back(specials[$urandom_range(0, 4)]);
            else
                text_q.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 7) != 0)
            text_q.push_back(8'h00);
    endtask

    initial
    begin
        logic [16:0] sizes[12];
        int          max_len;
        specials = '{CHR_AMP, CHR_LT, CHR_GT, CHR_QUOT, CHR_APOS};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default size: extremes of the byte and every escaped character
        text_q = '{8'h61, 8'h01, 8'hff, 8'h80, 8'h7f, CHR_AMP, CHR_LT, CHR_GT,
                   CHR_QUOT, CHR_APOS, 8'h00};
        wait_idle();

        // entity dropped, output full, entity that fits exactly
        set_buffer_size(17'd6);
        text_q = '{8'h61, 8'h62, CHR_LT, 8'h63, 8'h64, 8'h65, 8'h66, 8'h00,
                   CHR_AMP, CHR_QUOT, 8'h00};
        wait_idle();

        set_buffer_size(17'd1);
        text_q = '{8'h61, CHR_AMP, 8'h00};
        wait_idle();

        sizes = '{17'd0, 17'd1, 17'd2, 17'd5, 17'd6, 17'd7, 17'd65536, 17'd131071,
                  17'd256, 17'($urandom_range(3, 40)), 17'($urandom_range(3, 40)),
                  17'($urandom_range(3, 40))};
        for (int p = 0; p < 12; p++)
        begin
            set_buffer_size(sizes[p]);
            max_len = (sizes[p] <= 17'd64) ? int'(sizes[p]) + 8 : 40;
            while (text_q.size() < PHASE_ITEMS)
                push_string(max_len);
            text_q.push_back(8'h00);
            wait_idle();
        end

        if (errors == 0 && escaped_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/hee_pkg.sv
hw/rtl/hee_front.sv
hw/rtl/hee_cmd_fifo.sv
hw/rtl/hee_back.sv
hw/rtl/html_entity_escaper.sv
tb/sv/html_entity_escaper_tb.sv
